// ===== src/sil_pkg.sv =====
// ----------------------------------------------------------------------------
// sil_pkg
// shared types and constants for the sorted integer list
// ----------------------------------------------------------------------------
`default_nettype none

package sil_pkg;

    localparam int CAPACITY = 8;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 3;
    localparam int ENT_W    = 4;
    localparam int STAT_W   = 2;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef enum logic [STAT_W-1:0]
    {
        STATUS_DONE   = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_EMPTY  = 2'd2,
        STATUS_ABSENT = 2'd3
    } status_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_PLACE,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

// ===== src/sorted_int_list_top.sv =====
// ----------------------------------------------------------------------------
// sorted_int_list_top
// bounded ascending list of signed integers with insert and delete
// ----------------------------------------------------------------------------
// sequence: an insert when full or a delete when empty goes straight to the
//   response; otherwise a read and compare per slot scanned, a shift read and
//   write per slot moved, a place for an insert, then the response; ready again
//   and result valid after that; one request at a time; a result still held stalls the next one
// reset: asynchronous, clears the entry count, sequencer and output valid;
//   slot contents are undefined until written
`default_nettype none

module sorted_int_list_top
    import sil_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // value
    input  wire logic [0:0]  s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // status, position, entries, zero pad
);

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [CNT_W-1:0]         used_reg, used_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]         at_reg, at_next;
    status_t                  status_reg, status_next;

    logic                     out_valid_reg, out_valid_next;
    logic [15:0]              out_data_reg, out_data_next;

    logic                     we;
    logic [ADDR_W-1:0]        waddr;
    logic signed [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0]        raddr;
    logic signed [DATA_W-1:0] rdata;
    logic [CNT_W-1:0]         src_idx;
    logic                     lt, eq, hit;
    logic [CNT_W-1:0]         idx_inc;
    logic [CNT_W-1:0]         idx_dec;

    sil_slot_ram u_ram
    (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // shared comparator
    assign lt  = value_reg < rdata;
    assign eq  = value_reg == rdata;
    assign hit = (op_reg == OP_INSERT) ? lt : eq;

    assign idx_inc = idx_reg + CNT_W'(1);
    assign idx_dec = idx_reg - CNT_W'(1);
    assign src_idx = (op_reg == OP_INSERT) ? idx_dec : idx_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        value_reg    <= value_next;
        idx_reg      <= idx_next;
        at_reg       <= at_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        at_next        = at_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        s_tready       = 1'b0;
        we             = 1'b0;
        waddr          = idx_reg[ADDR_W-1:0];
        wdata          = rdata;
        raddr          = idx_reg[ADDR_W-1:0];

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next     = op_t'(s_tuser[0]);
                    value_next  = s_tdata;
                    idx_next    = '0;
                    at_next     = '0;
                    status_next = STATUS_DONE;
                    if (op_t'(s_tuser[0]) == OP_INSERT)
                    begin
                        if (used_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = STATUS_FULL;
                            state_next  = ST_RESP;
                        end
                        else if (used_reg == '0)
                        begin
                            state_next = ST_PLACE;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        if (used_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                            state_next  = ST_RESP;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end

            ST_READ:
            begin
                raddr      = idx_reg[ADDR_W-1:0];
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                if (hit)
                begin
                    at_next = idx_reg;
                    if (op_reg == OP_INSERT)
                    begin
                        idx_next   = used_reg;
                        state_next = ST_SHIFT_RD;
                    end
                    else if (idx_inc < used_reg)
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        used_next  = used_reg - CNT_W'(1);
                        state_next = ST_RESP;
                    end
                end
                else if (idx_inc == used_reg)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        at_next    = used_reg;
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        status_next = STATUS_ABSENT;
                        state_next  = ST_RESP;
                    end
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = ST_READ;
                end
            end

            ST_SHIFT_RD:
            begin
                raddr      = src_idx[ADDR_W-1:0];
                state_next = ST_SHIFT_WR;
            end

            ST_SHIFT_WR:
            begin
                we    = 1'b1;
                waddr = idx_reg[ADDR_W-1:0];
                wdata = rdata;
                if (op_reg == OP_INSERT)
                begin
                    idx_next = idx_dec;
                    if (idx_dec == at_reg)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                    if ((idx_inc + CNT_W'(1)) < used_reg)
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                    else
                    begin
                        used_next  = used_reg - CNT_W'(1);
                        state_next = ST_RESP;
                    end
                end
            end

            ST_PLACE:
            begin
                we         = 1'b1;
                waddr      = at_reg[ADDR_W-1:0];
                wdata      = value_reg;
                used_next  = used_reg + CNT_W'(1);
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[STAT_W-1:0] = status_reg;
                    if (status_reg == STATUS_DONE)
                    begin
                        out_data_next[STAT_W +: POS_W] = POS_W'(at_reg);
                    end
                    out_data_next[STAT_W+POS_W +: ENT_W] = ENT_W'(used_reg);
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== src/sil_slot_ram.sv =====
// ----------------------------------------------------------------------------
// sil_slot_ram
// slot storage, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sil_slot_ram
    import sil_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [ADDR_W-1:0]        waddr,
    input  wire logic signed [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0]        raddr,
    output logic signed [DATA_W-1:0]      rdata
);

    logic signed [DATA_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== tb/sorted_int_list_checker.sv =====
// ----------------------------------------------------------------------------
// sorted_int_list_checker
// watches both stream channels, predicts each result and compares it
// ----------------------------------------------------------------------------
// keeps its own copy of the ascending list, updates it for every accepted
// request and queues the result that request must give; every accepted
// result is compared field by field with the oldest queued one

module sorted_int_list_checker
    import sil_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,    // value
    input  logic [0:0]  s_tuser,    // op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,    // status, position, entries, zero pad
    output int          errors,
    output int          outstanding,
    output int          inserts,
    output int          deletes,
    output int          full_hits,
    output int          empty_hits,
    output int          absent_hits
);

    typedef struct packed
    {
        logic [6:0]       pad;
        logic [ENT_W-1:0] entries;
        logic [POS_W-1:0] position;
        status_t          status;
    } list_result_t;

    logic signed [DATA_W-1:0] list_vals [CAPACITY];
    int                       held = 0;
    list_result_t             expected_results [$];
    list_result_t             got;
    list_result_t             want;

    initial
    begin
        errors      = 0;
        outstanding = 0;
        inserts     = 0;
        deletes     = 0;
        full_hits   = 0;
        empty_hits  = 0;
        absent_hits = 0;
    end

    function automatic list_result_t predict_list_update(op_t op,
                                                         logic signed [DATA_W-1:0] val);
        list_result_t r;
        int           at;
        r  = '0;
        at = held;
        if (op == OP_INSERT)
        begin
            if (held >= CAPACITY)
                r.status = STATUS_FULL;
            else
            begin
                // first stored value strictly greater, so equal values keep order
                for (int i = 0; i < held; i++)
                    if (at == held && val < list_vals[i])
                        at = i;
                for (int i = held; i > at; i--)
                    list_vals[i] = list_vals[i-1];
                list_vals[at] = val;
                held++;
                r.status   = STATUS_DONE;
                r.position = POS_W'(at);
            end
        end
        else if (held == 0)
            r.status = STATUS_EMPTY;
        else
        begin
            for (int i = 0; i < held; i++)
                if (at == held && list_vals[i] == val)
                    at = i;
            if (at == held)
                r.status = STATUS_ABSENT;
            else
            begin
                for (int i = at; i + 1 < held; i++)
                    list_vals[i] = list_vals[i+1];
                held--;
                r.status   = STATUS_DONE;
                r.position = POS_W'(at);
            end
        end
        r.entries = ENT_W'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held = 0;
            expected_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = list_result_t'(m_tdata);
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: status %0d position %0d entries %0d pad %0h",
                                 got.status, got.position, got.entries, got.pad);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.position !== want.position ||
                        got.entries !== want.entries || got.pad !== want.pad)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected status %0d position %0d entries %0d pad %0h, got status %0d position %0d entries %0d pad %0h",
                                     want.status, want.position, want.entries, want.pad,
                                     got.status, got.position, got.entries, got.pad);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = predict_list_update(op_t'(s_tuser[0]), s_tdata);
                expected_results.push_back(want);
                if (op_t'(s_tuser[0]) == OP_INSERT)
                    inserts++;
                else
                    deletes++;
                case (want.status)
                    STATUS_FULL:   full_hits++;
                    STATUS_EMPTY:  empty_hits++;
                    STATUS_ABSENT: absent_hits++;
                    default:       ;
                endcase
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ===== tb/sorted_int_list_top_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_int_list_top_tb
// stimulus and verdict for the sorted integer list
// ----------------------------------------------------------------------------
// a directed run over the value extremes, duplicates, full, empty and
// not-found cases, then random insert and delete bursts under four idling
// phases; the checker beside the block predicts and compares every result

module sorted_int_list_top_tb;

    import sil_pkg::*;

    localparam int RANDOM_PER_PHASE = 500;
    localparam int DRAIN_CYCLES     = 4 * CAPACITY + 4;
    localparam int DIRECTED_COUNT   = 24;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    int errors;
    int outstanding;
    int inserts;
    int deletes;
    int full_hits;
    int empty_hits;
    int absent_hits;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int sender_idle [4]    = '{0, 65, 0, 8};
    int receiver_stall [4] = '{0, 0, 65, 8};

    op_t dir_ops [DIRECTED_COUNT] = '{
        OP_DELETE, OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT,
        OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT, OP_DELETE, OP_DELETE,
        OP_DELETE, OP_DELETE, OP_DELETE, OP_DELETE, OP_DELETE, OP_DELETE,
        OP_DELETE, OP_DELETE, OP_INSERT, OP_INSERT, OP_DELETE, OP_DELETE
    };
    logic [31:0] dir_vals [DIRECTED_COUNT] = '{
        32'd5,          32'd0,          32'h7fff_ffff, 32'h8000_0000,
        32'hffff_ffff,  32'd0,          32'd1,         32'h7fff_ffff,
        32'h8000_0000,  32'd42,         32'd42,        32'h8000_0000,
        32'h7fff_ffff,  32'd0,          32'hffff_ffff, 32'h7fff_ffff,
        32'h8000_0000,  32'd0,          32'd1,         32'd1,
        32'h5555_5555,  32'haaaa_aaaa,  32'h5555_5555, 32'haaaa_aaaa
    };

    sorted_int_list_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sorted_int_list_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding),
        .inserts     (inserts),
        .deletes     (deletes),
        .full_hits   (full_hits),
        .empty_hits  (empty_hits),
        .absent_hits (absent_hits)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    task automatic send_request(input op_t op, input logic [31:0] val);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom_range(1));
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin
        int          burst_left;
        int          insert_bias;
        int          choice;
        op_t         op;
        logic [31:0] val;

        burst_left  = 0;
        insert_bias = 50;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < DIRECTED_COUNT; n++)
            send_request(dir_ops[n], dir_vals[n]);

        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct    = sender_idle[ph];
            receiver_stall_pct = receiver_stall[ph];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // bursts lean towards insert or delete to reach full and empty
                if (burst_left == 0)
                begin
                    burst_left  = $urandom_range(40, 12);
                    insert_bias = 25 * $urandom_range(3, 1);
                end
                burst_left--;
                op     = ($urandom_range(99) < insert_bias) ? OP_INSERT : OP_DELETE;
                choice = $urandom_range(99);
                if (choice < 60)
                    val = $urandom_range(6) - 3;
                else if (choice < 75)
                begin
                    case ($urandom_range(5))
                        0:       val = 32'h8000_0000;
                        1:       val = 32'h8000_0001;
                        2:       val = 32'h7fff_fffe;
                        3:       val = 32'h7fff_ffff;
                        4:       val = '0;
                        default: val = '1;
                    endcase
                end
                else
                    val = $urandom;
                send_request(op, val);
            end
        end
        s_tvalid <= 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);

        $display("covered %0d requests: %0d inserts, %0d deletes, four idling phases",
                 inserts + deletes, inserts, deletes);
        $display("special results seen: %0d full, %0d empty, %0d not found",
                 full_hits, empty_hits, absent_hits);
        if (errors == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
